// ----- hw/rtl/rpn_pkg.sv -----
// Shared types and constants for the postfix evaluator.
`default_nettype none
package rpn_pkg;
   localparam int StackDepth = 64;
   localparam int VarCount = 16;
   localparam int SpWidth = 7;
   localparam int SaWidth = 6;
   localparam int VaWidth = 4;

   localparam logic [1:0] CMD_PUSH_CONST = 2'd0;
   localparam logic [1:0] CMD_PUSH_VAR = 2'd1;
   localparam logic [1:0] CMD_APPLY = 2'd2;
   localparam logic [1:0] CMD_LOAD = 2'd3;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_ADD = 3'd1;
   localparam logic [2:0] ERR_SUB = 3'd2;
   localparam logic [2:0] ERR_MUL = 3'd3;
   localparam logic [2:0] ERR_DIVZERO = 3'd4;
   localparam logic [2:0] ERR_DIVOVF = 3'd5;
   localparam logic [2:0] ERR_UNDER = 3'd6;
   localparam logic [2:0] ERR_OVER = 3'd7;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch the incoming beat
      logic rd_lhs;       // issue stack read of second entry
      logic rd_rhs;       // issue stack read of top entry
      logic take_lhs;     // stack read data is lhs
      logic take_rhs;     // stack read data is rhs
      logic exec;         // start the operation
      logic commit;       // write back and update pointer/error
      logic rd_top;       // read top for the response
      logic rsp_load;     // build response
   } rpn_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_ops;
      logic op_done;
      logic needs_top;
   } rpn_sts_type;
endpackage
`default_nettype wire

// ----- hw/rtl/rpn_checked_int_evaluator.sv -----
// Top level of the checked postfix evaluator.
// One token per beat; each token yields one result beat, and one token is in
// flight at a time. Push, load, and an operator that meets too few entries or
// a pending error go from decode straight to commit; other operators first
// read both operands through the single stack read port, then execute, with
// multiply adding a product stage and divide waiting on the one-bit-per-cycle
// divider. A result waits in an output register while the next token is taken;
// only the next result step stalls until that register is drained.
`default_nettype none
module rpn_checked_int_evaluator
   import rpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // value[31:0], var_index[35:32], operator_code[37:36], pad
   input  wire logic [39:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // top_value[31:0], stack_depth[38:32], error_code[41:39], pad
   output      logic [47:0] rsp_tdata,
   output      logic        rsp_tlast
);
   rpn_cmd_type cmd;
   rpn_sts_type sts;
   logic [31:0] top_value;
   logic [6:0]  stack_depth;
   logic [2:0]  error_code;

   rpn_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd);

   rpn_datapath u_dp (
      .clock, .reset, .cmd,
      .command(req_tuser), .value(req_tdata[31:0]),
      .var_index(req_tdata[35:32]), .operator_code(req_tdata[37:36]),
      .last(req_tlast), .sts, .top_value, .stack_depth, .error_code,
      .result_ready(rsp_tlast));

   assign rsp_tdata = {6'd0, error_code, stack_depth, top_value};
endmodule
`default_nettype wire

// ----- hw/rtl/rpn_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module rpn_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/rpn_divider.sv -----
// Iterative unsigned-magnitude divider, one quotient bit per cycle.
`default_nettype none
module rpn_divider
   import rpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output      logic        done,
   output      logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/rpn_datapath.sv -----
// Operand stack, variable table, arithmetic and checks.
`default_nettype none
module rpn_datapath
   import rpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rpn_cmd_type cmd,
   input  wire logic [1:0]  command,
   input  wire logic [31:0] value,
   input  wire logic [3:0]  var_index,
   input  wire logic [1:0]  operator_code,
   input  wire logic        last,
   output      rpn_sts_type sts,
   output      logic [31:0] top_value,
   output      logic [6:0]  stack_depth,
   output      logic [2:0]  error_code,
   output      logic        result_ready
);
   logic [1:0]  cmd_ff;
   logic [31:0] val_ff;
   logic [3:0]  vix_ff;
   logic [1:0]  op_ff;
   logic        last_ff;
   logic [SpWidth-1:0] sp_ff, sp_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] var_ff [VarCount];
   logic [VarCount-1:0] var_vld_ff;
   logic [31:0] lhs_ff, rhs_ff;
   logic [31:0] res_ff;
   logic [2:0]  code_ff;
   logic        done_ff;
   logic [63:0] prod_ff;
   logic        mul_ff;
   logic        negq_ff;
   logic [31:0] top_ff;
   logic [6:0]  depth_ff;
   logic [2:0]  ecode_ff;
   logic        rr_ff;
   logic        top_zero_ff;

   // stack RAM
   logic                wr_en;
   logic [SaWidth-1:0]  wr_addr, rd_addr;
   logic [31:0]         wr_data, rd_data;
   rpn_ram #(.Width(32), .Depth(StackDepth)) u_stack (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   // divider
   logic        div_start, div_done;
   logic [31:0] div_q, lmag, rmag;
   assign lmag = lhs_ff[31] ? -lhs_ff : lhs_ff;
   assign rmag = rhs_ff[31] ? -rhs_ff : rhs_ff;
   rpn_divider u_div (
      .clock, .reset, .start(div_start), .dividend(lmag), .divisor(rmag),
      .done(div_done), .quotient(div_q));

   logic ok_state;
   logic full;
   logic vix_ok;
   logic [31:0] var_rd;
   assign ok_state = (err_ff == ERR_NONE);
   assign full = (sp_ff >= SpWidth'(StackDepth));
   assign vix_ok = (32'(vix_ff) < 32'(VarCount));
   assign var_rd = (vix_ok && var_vld_ff[vix_ff[VaWidth-1:0]]) ?
                   var_ff[vix_ff[VaWidth-1:0]] : 32'd0;

   assign sts.needs_ops = ok_state && (cmd_ff == CMD_APPLY) && (sp_ff >= SpWidth'(2));
   assign sts.op_done = done_ff;
   assign sts.needs_top = 1'b1;

   always_comb begin
      rd_addr = '0;
      if (cmd.rd_lhs) rd_addr = SaWidth'(sp_ff - SpWidth'(2));
      else if (cmd.rd_rhs || cmd.rd_top) rd_addr = SaWidth'(sp_ff - SpWidth'(1));
   end

   // 33-bit add/sub checks
   logic [32:0] sum, dif;
   assign sum = {lhs_ff[31], lhs_ff} + {rhs_ff[31], rhs_ff};
   assign dif = {lhs_ff[31], lhs_ff} - {rhs_ff[31], rhs_ff};
   assign div_start = cmd.exec && (op_ff == OP_DIV) && (rhs_ff != 32'd0) &&
                      !(lhs_ff == 32'h8000_0000 && rhs_ff == 32'hFFFF_FFFF);

   // commit step
   always_comb begin
      sp_in = sp_ff;
      err_in = err_ff;
      wr_en = 1'b0;
      wr_addr = SaWidth'(sp_ff);
      wr_data = val_ff;
      if (cmd.commit && cmd_ff != CMD_LOAD && ok_state) begin
         if (cmd_ff == CMD_APPLY) begin
            if (sp_ff < SpWidth'(2)) err_in = ERR_UNDER;
            else if (code_ff != ERR_NONE) err_in = code_ff;
            else begin
               wr_en = 1'b1;
               wr_addr = SaWidth'(sp_ff - SpWidth'(2));
               wr_data = res_ff;
               sp_in = sp_ff - SpWidth'(1);
            end
         end else if (full) begin
            err_in = ERR_OVER;
         end else begin
            wr_en = 1'b1;
            wr_data = (cmd_ff == CMD_PUSH_VAR) ? var_rd : val_ff;
            sp_in = sp_ff + SpWidth'(1);
         end
      end
      if (cmd.rsp_load && last_ff) begin
         sp_in = '0;
         err_in = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         err_ff <= ERR_NONE;
         var_vld_ff <= '0;
         done_ff <= 1'b0;
         mul_ff <= 1'b0;
         rr_ff <= 1'b0;
      end else begin
         sp_ff <= sp_in;
         err_ff <= err_in;
         if (cmd.commit && cmd_ff == CMD_LOAD && vix_ok)
            var_vld_ff[vix_ff[VaWidth-1:0]] <= 1'b1;
         // result ready the cycle after exec, or once the multiply or divider finishes
         done_ff <= 1'b0;
         mul_ff <= 1'b0;
         if (cmd.exec) begin
            if (op_ff == OP_MUL) mul_ff <= 1'b1;
            else if (!div_start) done_ff <= 1'b1;
         end
         if (mul_ff || div_done) done_ff <= 1'b1;
         if (cmd.rsp_load) rr_ff <= last_ff;
      end
      if (cmd.commit && cmd_ff == CMD_LOAD && vix_ok)
         var_ff[vix_ff[VaWidth-1:0]] <= val_ff;
      if (cmd.capture) begin
         cmd_ff <= command;
         val_ff <= value;
         vix_ff <= var_index;
         op_ff <= operator_code;
         last_ff <= last;
      end
      if (cmd.take_lhs) lhs_ff <= rd_data;
      if (cmd.take_rhs) rhs_ff <= rd_data;
      if (cmd.exec) begin
         prod_ff <= 64'($signed(lhs_ff) * $signed(rhs_ff));
         negq_ff <= lhs_ff[31] ^ rhs_ff[31];
         code_ff <= ERR_NONE;
         case (op_ff)
            OP_ADD: begin
               res_ff <= sum[31:0];
               if (sum[32] != sum[31]) code_ff <= ERR_ADD;
            end
            OP_SUB: begin
               res_ff <= dif[31:0];
               if (dif[32] != dif[31]) code_ff <= ERR_SUB;
            end
            OP_MUL: res_ff <= '0;
            default: begin
               if (rhs_ff == 32'd0) code_ff <= ERR_DIVZERO;
               else if (lhs_ff == 32'h8000_0000 && rhs_ff == 32'hFFFF_FFFF)
                  code_ff <= ERR_DIVOVF;
            end
         endcase
      end
      if (mul_ff) begin
         res_ff <= prod_ff[31:0];
         if (prod_ff[63:31] != {33{prod_ff[31]}}) code_ff <= ERR_MUL;
      end
      if (div_done) res_ff <= negq_ff ? -div_q : div_q;
      if (cmd.rsp_load) begin
         top_ff <= rd_data;
         top_zero_ff <= (sp_ff == '0);
         depth_ff <= 7'(sp_ff);
         ecode_ff <= err_ff;
      end
   end

   assign top_value = top_zero_ff ? 32'd0 : top_ff;
   assign stack_depth = depth_ff;
   assign error_code = ecode_ff;
   assign result_ready = rr_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/rpn_control.sv -----
// Token sequencer for the evaluator.
`default_nettype none
module rpn_control
   import rpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire rpn_sts_type sts,
   output      rpn_cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD_LHS, S_RD_RHS, S_EXEC, S_WAIT,
      S_COMMIT, S_RD_TOP, S_RSP, S_HOLD
   } state_type;
   state_type state_ff, state_in;
   logic vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff;
      cmd = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.capture = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: state_in = sts.needs_ops ? S_RD_LHS : S_COMMIT;
         S_RD_LHS: begin
            cmd.rd_lhs = 1'b1;
            state_in = S_RD_RHS;
         end
         S_RD_RHS: begin
            cmd.rd_rhs = 1'b1;
            cmd.take_lhs = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.take_rhs = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.exec = 1'b1;
            state_in = S_HOLD;
         end
         S_HOLD: if (sts.op_done) state_in = S_COMMIT;
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_RD_TOP;
         end
         S_RD_TOP: begin
            cmd.rd_top = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            // keep the top read alive while the output register is held
            cmd.rd_top = 1'b1;
            if (!vld_ff || rsp_tready) begin
               cmd.rsp_load = sts.needs_top;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;
endmodule
`default_nettype wire

// ----- verif/rpn_checker.sv -----
// Checker for the postfix evaluator: watches both streams, predicts, compares.
`timescale 1ns / 1ps
module rpn_checker
   import rpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               pending_count,
   output int               token_count,
   output int               error_seen
);
   localparam longint I32Max = 64'sd2147483647;
   localparam longint I32Min = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] top_value;
      logic [6:0]  stack_depth;
      logic [2:0]  error_code;
      logic        done;
   } eval_result_type;

   logic [31:0]     operands [StackDepth];
   logic [31:0]     var_table [VarCount];
   int              depth;
   logic [2:0]      sticky;
   eval_result_type expected_q [$];

   assign pending_count = expected_q.size();

   function automatic logic [2:0] op_check(input logic [1:0] op, input longint a,
                                           input longint b, output longint r);
      r = 0;
      case (op)
         OP_ADD: begin
            r = a + b;
            if (r > I32Max || r < I32Min) return ERR_ADD;
         end
         OP_SUB: begin
            r = a - b;
            if (r > I32Max || r < I32Min) return ERR_SUB;
         end
         OP_MUL: begin
            r = a * b;
            if (r > I32Max || r < I32Min) return ERR_MUL;
         end
         default: begin
            if (b == 0) return ERR_DIVZERO;
            if (a == I32Min && b == -1) return ERR_DIVOVF;
            r = a / b;
         end
      endcase
      return ERR_NONE;
   endfunction

   task automatic predict_token(input logic [1:0] cmd, input logic [39:0] d,
                                input logic is_last);
      logic [31:0]     val;
      logic [3:0]      idx;
      longint          res;
      logic [2:0]      code;
      eval_result_type e;
      val = d[31:0]; idx = d[35:32];
      if (cmd == CMD_LOAD) begin
         var_table[idx] = val;
      end else if (sticky == ERR_NONE) begin
         if (cmd == CMD_APPLY) begin
            if (depth < 2) begin
               sticky = ERR_UNDER;
            end else begin
               code = op_check(d[37:36], longint'($signed(operands[depth-2])),
                               longint'($signed(operands[depth-1])), res);
               if (code != ERR_NONE) sticky = code;
               else begin
                  operands[depth-2] = res[31:0];
                  depth--;
               end
            end
         end else if (depth >= StackDepth) begin
            sticky = ERR_OVER;
         end else begin
            operands[depth] = (cmd == CMD_PUSH_CONST) ? val : var_table[idx];
            depth++;
         end
      end
      e.top_value = (depth > 0) ? operands[depth-1] : 32'd0;
      e.stack_depth = depth[6:0];
      e.error_code = sticky;
      e.done = is_last;
      if (sticky != ERR_NONE) error_seen++;
      expected_q.push_back(e);
      if (is_last) begin
         depth = 0;
         sticky = ERR_NONE;
      end
   endtask

   always @(posedge clock) begin
      eval_result_type e;
      if (reset) begin
         depth = 0;
         sticky = ERR_NONE;
         foreach (var_table[i]) var_table[i] = '0;
         expected_q.delete();
         fail_count <= 0;
         token_count <= 0;
         error_seen = 0;
      end else begin
         // result of this edge checked before predicting a token taken on it
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[31:0] !== e.top_value || rsp_tdata[38:32] !== e.stack_depth
                   || rsp_tdata[41:39] !== e.error_code || rsp_tlast !== e.done) begin
                  $display({"%0t: mismatch exp top=%h depth=%0d err=%0d last=%b",
                            " act top=%h depth=%0d err=%0d last=%b"},
                           $time, e.top_value, e.stack_depth, e.error_code, e.done,
                           rsp_tdata[31:0], rsp_tdata[38:32], rsp_tdata[41:39],
                           rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_token(req_tuser, req_tdata, req_tlast);
            token_count <= token_count + 1;
         end
      end
   end
endmodule

// ----- verif/tb_top.sv -----
// Stimulus and verdict for the postfix evaluator testbench.
`timescale 1ns / 1ps
module tb_top;
   import rpn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count, pending_count, token_count, error_seen;
   int          live_depth;
   bit          stim_done = 0;

   always #5 clock = ~clock;

   rpn_checked_int_evaluator dut (.*);
   rpn_checker chk (.*);

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return 32'd1;
         5: return $urandom;
         6: return $urandom_range(0, 65535) - 32768;
         default: return $urandom_range(0, 200) - 100;
      endcase
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   // drop valid and wait for the next clock edge
   task automatic bus_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // send one token; local model of depth keeps streams mostly well-formed
   task automatic send_token(input logic [1:0] cmd, input logic [31:0] val,
                             input logic [3:0] idx, input logic [1:0] op, input logic is_last,
                             input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         bus_idle();
         idle_gap();
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'd0, op, idx, val};
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_APPLY) live_depth = (live_depth > 1) ? live_depth - 1 : live_depth;
      else if (cmd != CMD_LOAD) live_depth++;
      if (is_last) live_depth = 0;
   endtask

   task automatic wait_drain();
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      logic [1:0] cmd;
      live_depth = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: each op, each error, extremes
      send_token(CMD_LOAD, 32'hffff_ffff, 4'hf, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_VAR, 32'd0, 4'hf, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_CONST, 32'h7fff_ffff, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_ADD, 1'b1, 1'b0);
      send_token(CMD_PUSH_CONST, 32'h7fff_ffff, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_CONST, 32'd1, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_LOAD, 32'h1234_5678, 4'h3, OP_SUB, 1'b1, 1'b0);
      send_token(CMD_PUSH_CONST, 32'h8000_0000, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_CONST, 32'd1, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_SUB, 1'b1, 1'b0);
      send_token(CMD_PUSH_CONST, 32'h0001_0000, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_VAR, 32'd0, 4'h3, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_MUL, 1'b1, 1'b0);
      send_token(CMD_PUSH_CONST, 32'h8000_0000, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_CONST, 32'hffff_ffff, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_DIV, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_DIV, 1'b1, 1'b0);
      send_token(CMD_PUSH_CONST, 32'hffff_fff9, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_PUSH_CONST, 32'd0, 4'h0, OP_ADD, 1'b0, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_DIV, 1'b1, 1'b0);
      send_token(CMD_APPLY, 32'd0, 4'h0, OP_ADD, 1'b1, 1'b0);
      // full stack then overflow
      for (int i = 0; i <= StackDepth; i++)
         send_token(CMD_PUSH_CONST, $urandom, 4'h0, OP_ADD, i == StackDepth, 1'b1);
      bus_idle();
      wait_drain();
      // random expressions
      sent = 0;
      while (sent < 1850) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: anything at all
            send_token(2'($urandom), $urandom, 4'($urandom), 2'($urandom),
                       $urandom_range(0, 3) == 0, 1'b1);
            sent++;
            continue;
         end
         len = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 10);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) cmd = CMD_LOAD;
            else if (live_depth >= 2 && $urandom_range(0, 1)) cmd = CMD_APPLY;
            else cmd = $urandom_range(0, 1) ? CMD_PUSH_CONST : CMD_PUSH_VAR;
            send_token(cmd, pick_value(), 4'($urandom), 2'($urandom),
                       (k == len - 1) && live_depth < 3, 1'b1);
            sent++;
         end
         while (live_depth >= 2) begin
            send_token(CMD_APPLY, 32'd0, 4'h0, 2'($urandom), live_depth == 2, 1'b1);
            sent++;
         end
         if (live_depth != 0) begin
            send_token(CMD_PUSH_CONST, pick_value(), 4'h0, OP_ADD, 1'b1, 1'b1);
            sent++;
         end
         if ($urandom_range(0, 99) == 0) begin
            bus_idle();
            wait_drain();
         end
      end
      bus_idle();
      stim_done = 1;
   end

   // receiver stalls, with a quiet stretch in the middle
   initial begin
      forever begin
         @(posedge clock);
         if (token_count > 600 && token_count < 900) rsp_tready <= 1;
         else if ($urandom_range(0, 19) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(5, 50)) @(posedge clock);
            rsp_tready <= 1;
         end else rsp_tready <= $urandom_range(0, 3) != 0;
      end
   end

   initial begin
      wait (stim_done);
      wait_drain();
      repeat (100) @(posedge clock);
      $display("covered %0d tokens, %0d results carried an error code", token_count,
               error_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
